// ----- src/pal_pkg.sv -----
// Shared types and constants for the positional array list.
package pal_pkg;

	localparam int DEF_CAPACITY = 128;

	localparam int KIND_W   = 3;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	// Request codes
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 3'd0,
		KIND_GET    = 3'd1,
		KIND_FIND   = 3'd2,
		KIND_INSERT = 3'd3,
		KIND_DELETE = 3'd4
	} kind_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_GET,
		S_FIND,
		S_INS,
		S_DEL,
		S_DONE
	} state_t;

	// One result beat, handed from the controller to the output register
	typedef struct packed {
		logic [7:0]              list_length;
		logic [7:0]              found_position;
		logic signed [VAL_W-1:0] read_value;
		status_t                 status;
	} result_t;

endpackage

// ----- src/pal_store.sv -----
// Element store: one write port, one read port, registered read data.
module pal_store #(
	parameter int Depth = pal_pkg::DEF_CAPACITY,
	parameter int AddrW = 7
) (
	input  logic                 clk,
	input  logic                 re,
	input  logic [AddrW-1:0]     rd_addr,
	output logic [pal_pkg::VAL_W-1:0] rd_data,
	input  logic                 we,
	input  logic [AddrW-1:0]     wr_addr,
	input  logic [pal_pkg::VAL_W-1:0] wr_data
);

	logic [pal_pkg::VAL_W-1:0] mem [Depth];
	logic [pal_pkg::VAL_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/pal_ctrl.sv -----
// Request sequencer: decodes a request and walks the store for find and shifts.
module pal_ctrl #(
	parameter int Capacity = pal_pkg::DEF_CAPACITY,
	parameter int AddrW    = 7,
	parameter int CntW     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pal_pkg::KIND_W-1:0]    in_kind,
	input  logic [pal_pkg::POS_W-1:0]     in_position,
	input  logic [pal_pkg::VAL_W-1:0]     in_value,
	// result side
	output logic                          res_valid,
	input  logic                          res_ready,
	output pal_pkg::result_t              res,
	// store port
	output logic                          mem_re,
	output logic [AddrW-1:0]              mem_raddr,
	input  logic [pal_pkg::VAL_W-1:0]     mem_rdata,
	output logic                          mem_we,
	output logic [AddrW-1:0]              mem_waddr,
	output logic [pal_pkg::VAL_W-1:0]     mem_wdata
);

	// wide enough for position, count and count + 1
	localparam int XW = ((CntW > pal_pkg::POS_W) ? CntW : pal_pkg::POS_W) + 1;

	pal_pkg::state_t  state_q, state_d;
	pal_pkg::kind_t   kind_q;
	logic [pal_pkg::POS_W-1:0] pos_q;
	logic [pal_pkg::VAL_W-1:0] value_q;
	logic [CntW-1:0]  count_q, count_d;
	logic [CntW-1:0]  idx_q, idx_d;
	logic             pend_s1, pend_d;
	logic [CntW-1:0]  addr_s1, addr_d;
	pal_pkg::status_t status_q, status_d;
	logic [pal_pkg::VAL_W-1:0] rdval_q, rdval_d;
	logic [7:0]       fpos_q, fpos_d;

	logic [XW-1:0]    pos_x, cnt_x;
	logic             pos_zero, pos_gt_cnt, pos_gt_cnt1, full, hit;
	logic [CntW-1:0]  pos_m1;

	// position checks
	assign pos_x       = XW'(pos_q);
	assign cnt_x       = XW'(count_q);
	assign pos_zero    = (pos_q == '0);
	assign pos_gt_cnt  = (pos_x > cnt_x);
	assign pos_gt_cnt1 = (pos_x > (cnt_x + XW'(1)));
	assign full        = (cnt_x == XW'(Capacity));
	assign pos_m1      = CntW'(pos_x - XW'(1));
	assign hit         = pend_s1 && (mem_rdata == value_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pal_pkg::S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= pend_d;
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= pal_pkg::kind_t'(in_kind);
			pos_q   <= in_position;
			value_q <= in_value;
		end
		idx_q    <= idx_d;
		addr_s1  <= addr_d;
		status_q <= status_d;
		rdval_q  <= rdval_d;
		fpos_q   <= fpos_d;
	end

	// next state, store accesses, result fields
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pend_d    = 1'b0;
		addr_d    = addr_s1;
		status_d  = status_q;
		rdval_d   = rdval_q;
		fpos_d    = fpos_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = addr_s1[AddrW-1:0];
		mem_wdata = mem_rdata;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			pal_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = pal_pkg::S_DECODE;
				end
			end

			pal_pkg::S_DECODE: begin
				status_d = pal_pkg::ST_OK;
				rdval_d  = '0;
				fpos_d   = '0;
				state_d  = pal_pkg::S_DONE;
				unique case (kind_q)
					pal_pkg::KIND_CLEAR: begin
						count_d = '0;
					end
					pal_pkg::KIND_GET: begin
						if (pos_zero || pos_gt_cnt) begin
							status_d = pal_pkg::ST_BADPOS;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = pos_m1[AddrW-1:0];
							state_d   = pal_pkg::S_GET;
						end
					end
					pal_pkg::KIND_FIND: begin
						idx_d   = '0;
						state_d = pal_pkg::S_FIND;
					end
					pal_pkg::KIND_INSERT: begin
						if (pos_zero || pos_gt_cnt1) begin
							status_d = pal_pkg::ST_BADPOS;
						end else if (full) begin
							status_d = pal_pkg::ST_FULL;
						end else begin
							idx_d   = count_q;
							state_d = pal_pkg::S_INS;
						end
					end
					pal_pkg::KIND_DELETE: begin
						if (pos_zero || pos_gt_cnt) begin
							status_d = pal_pkg::ST_BADPOS;
						end else begin
							idx_d   = pos_x[CntW-1:0];
							state_d = pal_pkg::S_DEL;
						end
					end
					default: ;
				endcase
			end

			pal_pkg::S_GET: begin
				rdval_d = mem_rdata;
				state_d = pal_pkg::S_DONE;
			end

			// scan from the front, compare in the cycle after the read
			pal_pkg::S_FIND: begin
				if (hit) begin
					fpos_d   = 8'(XW'(addr_s1) + XW'(1));
					status_d = pal_pkg::ST_OK;
					state_d  = pal_pkg::S_DONE;
				end else if (idx_q == count_q) begin
					status_d = pal_pkg::ST_MISS;
					state_d  = pal_pkg::S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AddrW-1:0];
					pend_d    = 1'b1;
					addr_d    = idx_q;
					idx_d     = idx_q + CntW'(1);
				end
			end

			// shift up from the tail: read j-1, write j in the cycle after
			pal_pkg::S_INS: begin
				if (pend_s1) begin
					mem_we = 1'b1;
				end
				if (idx_q != pos_m1) begin
					mem_re    = 1'b1;
					mem_raddr = AddrW'(idx_q - CntW'(1));
					pend_d    = 1'b1;
					addr_d    = idx_q;
					idx_d     = idx_q - CntW'(1);
				end else if (!pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pos_m1[AddrW-1:0];
					mem_wdata = value_q;
					count_d   = count_q + CntW'(1);
					state_d   = pal_pkg::S_DONE;
				end
			end

			// shift down toward the gap: read j, write j-1 in the cycle after
			pal_pkg::S_DEL: begin
				if (pend_s1) begin
					mem_we = 1'b1;
				end
				if (idx_q != count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AddrW-1:0];
					pend_d    = 1'b1;
					addr_d    = idx_q - CntW'(1);
					idx_d     = idx_q + CntW'(1);
				end else if (!pend_s1) begin
					count_d = count_q - CntW'(1);
					state_d = pal_pkg::S_DONE;
				end
			end

			pal_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = pal_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = pal_pkg::S_IDLE;
			end
		endcase
	end

	// result beat
	always_comb begin
		res.status         = status_q;
		res.read_value     = rdval_q;
		res.found_position = fpos_q;
		res.list_length    = 8'(count_q);
	end

	// a shift never reads the entry it writes in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("store read and write hit the same entry");

	// the count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Capacity))
		else $error("entry count above capacity");

	// a completed insert grows the list by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pal_pkg::S_INS && state_d == pal_pkg::S_DONE)
		|=> (count_q == $past(count_q) + CntW'(1)))
		else $error("insert did not grow the list");

	// no read is left in flight between requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pal_pkg::S_IDLE || state_q == pal_pkg::S_DONE) |-> !pend_s1)
		else $error("store read in flight outside a walk");

endmodule

// ----- src/positional_array_list.sv -----
// Positional array list: an ordered list of up to CAPACITY signed 32-bit words held in one
// single-port-read, single-port-write store with a length count. One request is worked at a
// time; with N entries and a 1-based position P, find compares up to N entries, insert
// shifts entries P to N up by one and delete shifts entries P + 1 to N down by one, each
// shift or compare moving one entry through the store's read and write ports per cycle.
// A new request is taken while the previous result still sits in the output register.
// The store has no reset; get and find only touch written entries.
module positional_array_list #(
	parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// kind[2:0], position[10:3], value[42:11], zero fill
	input  logic [pal_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status[1:0], read_value[33:2], found_position[41:34], list_length[49:42], zero fill
	output logic [pal_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CntW  = $clog2(CAPACITY + 1);

	logic                      mem_re, mem_we;
	logic [AddrW-1:0]          mem_raddr, mem_waddr;
	logic [pal_pkg::VAL_W-1:0] mem_rdata, mem_wdata;
	logic                      res_valid, res_ready;
	pal_pkg::result_t          res;
	logic                      out_valid_q;
	pal_pkg::result_t          out_q;

	pal_store #(
		.Depth (CAPACITY),
		.AddrW (AddrW)
	) u_store (
		.clk     (clk),
		.re      (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata),
		.we      (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	pal_ctrl #(
		.Capacity (CAPACITY),
		.AddrW    (AddrW),
		.CntW     (CntW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_kind     (s_axis_tdata[2:0]),
		.in_position (s_axis_tdata[10:3]),
		.in_value    (s_axis_tdata[42:11]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_q.list_length, out_q.found_position,
		out_q.read_value, out_q.status};

endmodule
